@@ design/linear_congruence_solver_unit_macros.svh @@
// Assertion macros for the linear congruence solver checker.
// No dependencies.
`ifndef LINEAR_CONGRUENCE_SOLVER_UNIT_MACROS_SVH
`define LINEAR_CONGRUENCE_SOLVER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define LCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcs check failed");
// next-cycle implication
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcs check failed");
`endif

@@ design/lcs_pkg.sv @@
// Package for the linear congruence solver: widths, payload structs, status
// codes and sequencer states. No dependencies.
package lcs_pkg;
    localparam int OPERAND_WIDTH = 31;
    localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

    typedef logic [OPERAND_WIDTH-1:0] t_op;

    typedef enum logic [1:0] {
        ST_SOLVED   = 2'd0,
        ST_NO_SOL   = 2'd1,
        ST_MOD_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        t_op coef_a;
        t_op rhs_b;
        t_op modulus;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        t_op        solution;
        t_op        reduced_modulus;
        t_op        common_divisor;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_INIT,    // start a shift-subtract division num / den
        S_DIV_STEP,    // one quotient bit per cycle
        S_DIV_DONE,    // dispatch on what the division was for
        S_EUC_UPD,     // Bezout update t2 = t0 - q*t1 mod mr
        S_MUL_STEP,    // modular multiply, one bit per cycle
        S_OUT
    } t_state;

    // division purposes
    typedef enum logic [2:0] {
        D_GCD, D_BMOD, D_MR, D_AR, D_BR, D_SEED, D_EUC
    } t_dsel;
endpackage

@@ design/linear_congruence_solver_unit.sv @@
// Linear congruence solver top level: one sequencer around a shared
// shift-subtract divider and modular adder. Depends on lcs_pkg.
//
// Solves coef_a*x = rhs_b (mod modulus) for one request at a time. The
// sequencer runs Euclid for d = gcd(a,m), divides out d, runs the extended
// Euclid for the inverse of a/d modulo m/d and forms (inv*b/d) mod (m/d).
// Every quotient comes from one restoring divider producing one bit per cycle
// (each division: load, one step per quotient bit, dispatch), and every
// modular product from one add-double step per multiplier bit plus a
// finishing step. A zero modulus goes straight from idle to the output step;
// a general request runs up to ~46 Euclid divisions for the gcd, four more
// for the reductions and one to seed the inverse, and up to ~46
// divide/multiply/update rounds for the inverse, so the worst case is set by
// the divider and the Bezout multiply loop. o_ready is high only while the
// sequencer is idle. The finished result moves into an output register, so
// the next request can be worked on while it waits; the sequencer stalls at
// its last step only when that register is still full and not being drained.
module linear_congruence_solver_unit
    import lcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_req  i_req,
    output logic  o_valid,
    input  logic  i_ready,
    output t_rsp  o_rsp
);
    t_state r_state, n_state;
    t_dsel  r_dsel, n_dsel;
    t_op r_a, n_a, r_b, n_b, r_m, n_m;
    t_op r_d, n_d, r_mr, n_mr;
    // Euclid registers
    t_op r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    // divider
    t_op r_num, n_num, r_den, n_den, r_quo, n_quo;
    logic [OPERAND_WIDTH:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    // modular multiply: acc += x when y bit set, x doubled
    t_op r_acc, n_acc, r_mx, n_mx, r_my, n_my;
    logic r_final, n_final;       // multiply is the final one
    logic r_vld, n_vld;
    t_rsp r_wrk, n_wrk;           // result under construction
    t_rsp r_rsp, n_rsp;           // output register

    // modular adder for the multiply step
    logic [OPERAND_WIDTH:0] add_s;
    t_op add_x, add_y, add_r;
    always_comb begin
        add_s = {1'b0, add_x} + {1'b0, add_y};
        add_r = (add_s >= {1'b0, r_mr}) ? t_op'(add_s - {1'b0, r_mr})
                                        : t_op'(add_s);
    end

    logic [OPERAND_WIDTH:0] trial;
    always_comb trial = {r_rem[OPERAND_WIDTH-1:0], r_num[OPERAND_WIDTH-1]};

    // doubling modulo mr (x < mr)
    function automatic t_op dbl(input t_op x);
        logic [OPERAND_WIDTH:0] s;
        s = {x, 1'b0};
        dbl = (s >= {1'b0, r_mr}) ? t_op'(s - {1'b0, r_mr}) : t_op'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
        end
        r_dsel <= n_dsel; r_a <= n_a; r_b <= n_b; r_m <= n_m;
        r_d <= n_d; r_mr <= n_mr; r_r0 <= n_r0; r_r1 <= n_r1;
        r_t0 <= n_t0; r_t1 <= n_t1; r_num <= n_num; r_den <= n_den;
        r_quo <= n_quo; r_rem <= n_rem; r_cnt <= n_cnt;
        r_acc <= n_acc; r_mx <= n_mx; r_my <= n_my; r_final <= n_final;
        r_wrk <= n_wrk; r_rsp <= n_rsp;
    end

    always_comb begin
        n_state = r_state; n_dsel = r_dsel;
        n_a = r_a; n_b = r_b; n_m = r_m; n_d = r_d; n_mr = r_mr;
        n_r0 = r_r0; n_r1 = r_r1; n_t0 = r_t0; n_t1 = r_t1;
        n_num = r_num; n_den = r_den; n_quo = r_quo; n_rem = r_rem;
        n_cnt = r_cnt; n_acc = r_acc; n_mx = r_mx; n_my = r_my;
        n_final = r_final; n_vld = r_vld; n_wrk = r_wrk; n_rsp = r_rsp;
        add_x = r_acc; add_y = r_mx;
        if (r_vld && i_ready) n_vld = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_a = i_req.coef_a; n_b = i_req.rhs_b; n_m = i_req.modulus;
                    n_wrk = '0;
                    if (i_req.modulus == '0) begin
                        n_wrk.status = ST_MOD_ZERO;
                        n_state = S_OUT;
                    end else if (i_req.coef_a == '0) begin
                        // gcd(0, m) = m: go straight to b mod d
                        n_d = i_req.modulus;
                        n_num = i_req.rhs_b; n_den = i_req.modulus;
                        n_dsel = D_BMOD;
                        n_state = S_DIV_INIT;
                    end else begin
                        // gcd(a, m): r0 = m, r1 = a
                        n_r0 = i_req.modulus; n_r1 = i_req.coef_a;
                        n_num = i_req.modulus; n_den = i_req.coef_a;
                        n_dsel = D_GCD;
                        n_state = S_DIV_INIT;
                    end
                end
            end
            S_DIV_INIT: begin
                n_rem = '0; n_quo = '0; n_cnt = CNT_W'(OPERAND_WIDTH);
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                if (trial >= {1'b0, r_den}) begin
                    n_rem = trial - {1'b0, r_den};
                    n_quo = {r_quo[OPERAND_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_quo = {r_quo[OPERAND_WIDTH-2:0], 1'b0};
                end
                n_num = {r_num[OPERAND_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) n_state = S_DIV_DONE;
            end
            S_DIV_DONE: begin
                n_state = S_DIV_INIT;
                case (r_dsel)
                    D_GCD: begin
                        // r_rem = r0 % r1
                        n_r0 = r_r1; n_r1 = t_op'(r_rem);
                        if (r_rem == '0) begin
                            n_d = r_r1;
                            n_num = r_b; n_den = r_r1; n_dsel = D_BMOD;
                        end else begin
                            n_num = r_r1; n_den = t_op'(r_rem);
                        end
                    end
                    D_BMOD: begin
                        n_wrk.common_divisor = r_d;
                        n_wrk.status = (r_rem != '0) ? ST_NO_SOL : ST_SOLVED;
                        n_num = r_m; n_den = r_d; n_dsel = D_MR;
                    end
                    D_MR: begin
                        n_mr = r_quo;
                        n_wrk.reduced_modulus = r_quo;
                        if (r_wrk.status == ST_NO_SOL) begin
                            n_state = S_OUT;
                        end else begin
                            n_num = r_a; n_den = r_d; n_dsel = D_AR;
                        end
                    end
                    D_AR: begin
                        n_a = r_quo;
                        n_num = r_b; n_den = r_d; n_dsel = D_BR;
                    end
                    D_BR: begin
                        n_b = r_quo;
                        // ar % mr seeds r1
                        n_num = r_a; n_den = r_mr; n_dsel = D_SEED;
                        n_r0 = r_mr;
                        n_t0 = '0; n_t1 = (r_mr == t_op'(1)) ? '0 : t_op'(1);
                    end
                    D_SEED: begin
                        n_r1 = t_op'(r_rem);
                        if (r_rem == '0) begin
                            // no Euclid rounds: inverse is t0
                            n_acc = '0; n_mx = r_t0; n_my = r_b;
                            n_final = 1'b1;
                            n_state = S_MUL_STEP;
                        end else begin
                            n_num = r_r0; n_den = t_op'(r_rem); n_dsel = D_EUC;
                        end
                    end
                    D_EUC: begin
                        // q = r0 / r1, r2 = r0 % r1; next form q*t1 mod mr
                        n_r0 = r_r1; n_r1 = t_op'(r_rem);
                        n_acc = '0; n_mx = r_t1; n_my = r_quo;
                        n_final = 1'b0;
                        n_state = S_MUL_STEP;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MUL_STEP: begin
                if (r_my == '0) begin
                    if (r_final) begin
                        n_wrk.solution = r_acc;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_EUC_UPD;
                    end
                end else begin
                    if (r_my[0]) n_acc = add_r;
                    n_my = r_my >> 1;
                    n_mx = dbl(r_mx);
                end
            end
            S_EUC_UPD: begin
                // t2 = t0 - acc mod mr; r0, r1 already advanced
                n_t0 = r_t1;
                n_t1 = (r_t0 >= r_acc) ? t_op'(r_t0 - r_acc)
                                       : t_op'(r_t0 + (r_mr - r_acc));
                if (r_r1 == '0) begin
                    // inverse is the new t0; multiply by br
                    n_acc = '0; n_mx = r_t1; n_my = r_b;
                    n_final = 1'b1;
                    n_state = S_MUL_STEP;
                end else begin
                    n_num = r_r0; n_den = r_r1; n_dsel = D_EUC;
                    n_state = S_DIV_INIT;
                end
            end
            S_OUT: begin
                // load the output register once it is free or being drained
                if (!r_vld || i_ready) begin
                    n_rsp = r_wrk;
                    n_vld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_vld;
    assign o_rsp   = r_rsp;
endmodule

@@ design/lcs_checker.sv @@
// Port-level checker for the linear congruence solver, bound to the top.
// Depends on lcs_pkg and the assertion macro header.
`include "linear_congruence_solver_unit_macros.svh"
module lcs_checker
    import lcs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input t_req i_req,
    input logic o_valid,
    input logic i_ready,
    input t_rsp o_rsp
);
    `LCS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `LCS_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_valid, o_rsp.status <= ST_MOD_ZERO)
    `LCS_ASSERT_IMPL(a_zero_mod_fields, i_clk, i_rst_n,
        o_valid && o_rsp.status == ST_MOD_ZERO,
        o_rsp.common_divisor == '0 && o_rsp.reduced_modulus == '0)
    `LCS_ASSERT_IMPL(a_sol_below_mod, i_clk, i_rst_n,
        o_valid && o_rsp.status == ST_SOLVED,
        o_rsp.solution < o_rsp.reduced_modulus)
    `LCS_ASSERT_NEXT(a_rsp_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_rsp))
endmodule

bind linear_congruence_solver_unit lcs_checker u_lcs_checker (.*);
